// ===== rtl/waveform_period_amplitude_meter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the waveform meter
// Each macro compiles to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_PERIOD_AMPLITUDE_METER_CORE_MACROS_SVH
`define WAVEFORM_PERIOD_AMPLITUDE_METER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WPAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WPAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WPAM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define WPAM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/wpam_pkg.sv =====
// ----------------------------------------------------------------------------
// Waveform meter package
// Shared constants, register indexes and types.
// ----------------------------------------------------------------------------
package wpam_pkg;
  localparam logic [2:0] REG_THR   = 3'd0;
  localparam logic [2:0] REG_PEN   = 3'd1;
  localparam logic [2:0] REG_PCOND = 3'd2;
  localparam logic [2:0] REG_SPF   = 3'd3;
  localparam logic [2:0] REG_STEP  = 3'd4;

  localparam logic [1:0] COND_RISE = 2'd0;
  localparam logic [1:0] COND_FALL = 2'd1;
  localparam logic [1:0] COND_HIGH = 2'd2;
  localparam logic [1:0] COND_LOW  = 2'd3;

  // most negative 33-bit value, -2^32
  localparam logic signed [32:0] MAX_RST  = {1'b1, 32'd0};
  localparam logic signed [32:0] MIN_RST  = 33'sd4294967295;
  localparam logic signed [32:0] DISP_RST = 33'sd5000000;
  localparam logic [63:0]        NO_WAVE  = 64'd10;

  // divider request/response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

// ===== rtl/wpam_divider.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring radix-2 unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpam_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wpam_pkg::div_req_t req_i,
  output wpam_pkg::div_rsp_t rsp_o
);
  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  // shift in next dividend bit and try subtract
  always_comb begin
    trial  = {rem_q[31:0], quo_q[63]};
    diff   = {1'b0, trial} - {2'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[32:0];
      end else begin
        rem_d = trial;
      end
      quo_d = {quo_q[62:0], ~diff[33]};
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== rtl/wpam_multiplier.sv =====
// ----------------------------------------------------------------------------
// Timeout multiplier
// 32x32 product, registered; used to form the lost-wave limit.
// ----------------------------------------------------------------------------
module wpam_multiplier (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  // one registered product
  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;
endmodule

// ===== rtl/waveform_period_amplitude_meter_core.sv =====
// ----------------------------------------------------------------------------
// Waveform period and amplitude meter
// Tracks extremes, peaks, period and pause conditions; averages on a tick.
// ----------------------------------------------------------------------------
// A sample beat passes through accept, update and output states. A frame tick
// passes through accept, multiply settle, timeout check and output when no
// average is due; when one is due the serial divider runs in between multiply
// settle and timeout check, one quotient bit per cycle, until its done flag.
// The input stalls while a beat is in progress and while a result waits on the
// output. No clearing pass after reset.
module waveform_period_amplitude_meter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind_i,
  input  logic [63:0]        time_ps_i,
  input  logic signed [30:0] voltage_a_i,
  input  logic signed [30:0] voltage_b_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pause_request_o,
  output logic               condition_flag_o,
  output logic [31:0]        amplitude_o,
  output logic [63:0]        period_ps_o,
  output logic signed [31:0] display_max_o,
  output logic signed [31:0] display_min_o,
  output logic [63:0]        average_period_ps_o,
  output logic               average_valid_o,
  output logic               wave_lost_o,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
`include "waveform_period_amplitude_meter_core_macros.svh"

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SAMP = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_TICK = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [29:0] thr_q;
  logic        pen_q;
  logic [1:0]  pcond_q;
  logic [31:0] spf_q, step_q;

  // measurement state
  logic               rise_q, rise_d, fall_q, fall_d, cond_q, cond_d;
  logic signed [32:0] last_q, last_d, max_q, max_d, min_q, min_d;
  logic signed [32:0] amp_q, amp_d, dmax_q, dmax_d, dmin_q, dmin_d;
  logic [63:0]        per_q, per_d, ret_q, ret_d, lmt_q, lmt_d, tot_q, tot_d;
  logic [31:0]        mcnt_q, mcnt_d;
  logic [15:0]        ccnt_q, ccnt_d;

  // item and result
  logic               kind_q;
  logic [63:0]        now_q;
  logic signed [31:0] data_q;
  logic               pause_q, pause_d, avv_q, avv_d, lost_q, lost_d;
  logic [63:0]        avg_q, avg_d;

  wpam_pkg::div_req_t div_req;
  wpam_pkg::div_rsp_t div_rsp;
  logic [63:0]        prod;

  wpam_divider u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  wpam_multiplier u_mul (.clk_i(clk_i), .a_i(spf_q), .b_i(step_q), .p_o(prod));

  logic in_acc;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_q != S_IDLE);

  // sample datapath
  logic signed [32:0] dat, nmax, nmin, delta, thr_s;
  logic signed [34:0] lhs, rhs;
  logic [63:0]        limit, spf2;
  logic [31:0]        mcm1;

  always_comb begin
    dat   = {data_q[31], data_q};
    thr_s = {3'b000, thr_q};
    nmax  = (dat > max_q) ? dat : max_q;
    nmin  = (dat < min_q) ? dat : min_q;
    delta = dat - last_q;
    lhs   = {dat[32], dat, 1'b0};
    rhs   = {{2{nmin[32]}}, nmin} + {{2{nmax[32]}}, nmax};
    mcm1  = mcnt_q - 32'd1;
    spf2  = {31'd0, spf_q, 1'b0};
    limit = (per_q << 1) < spf2 ? (prod << 1) : (per_q << 1);
  end

  always_comb begin
    state_d = state_q;
    rise_d = rise_q; fall_d = fall_q; cond_d = cond_q;
    last_d = last_q; max_d = max_q; min_d = min_q;
    amp_d = amp_q; dmax_d = dmax_q; dmin_d = dmin_q;
    per_d = per_q; ret_d = ret_q; lmt_d = lmt_q; tot_d = tot_q;
    mcnt_d = mcnt_q; ccnt_d = ccnt_q;
    pause_d = pause_q; avv_d = avv_q; lost_d = lost_q; avg_d = avg_q;
    div_req.start    = 1'b0;
    div_req.dividend = tot_q;
    div_req.divisor  = mcm1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pause_d = 1'b0; avv_d = 1'b0; lost_d = 1'b0; avg_d = '0;
          state_d = kind_i ? S_MUL : S_SAMP;
        end
      end
      S_SAMP: begin
        max_d = nmax;
        min_d = nmin;
        if (delta > 0) begin
          if (delta > thr_s) begin
            if (fall_q && !rise_q) begin
              if (mcnt_q != 0) tot_d = tot_q + (now_q - lmt_q);
              lmt_d  = now_q;
              mcnt_d = mcnt_q + 32'd1;
              ccnt_d = ccnt_q + 16'd1;
              fall_d = 1'b0;
              if (pen_q) begin
                if (pcond_q == wpam_pkg::COND_RISE) begin
                  pause_d = 1'b1; cond_d = 1'b0;
                end else if (pcond_q == wpam_pkg::COND_HIGH) begin
                  pause_d = 1'b1; cond_d = 1'b1;
                end else if (pcond_q == wpam_pkg::COND_LOW) begin
                  cond_d = 1'b0;
                end
              end
            end else if (pen_q && pcond_q == wpam_pkg::COND_RISE) begin
              cond_d = 1'b0;
            end
            rise_d = 1'b1;
            last_d = dat;
          end
          if (ccnt_d > 16'd1) begin
            amp_d = nmax - nmin;
            if (lhs >= rhs) begin
              if (mcnt_d > 32'd1) begin
                dmax_d = nmax; dmin_d = nmin;
                max_d = wpam_pkg::MAX_RST; min_d = wpam_pkg::MIN_RST;
              end
              ccnt_d = ccnt_d - 16'd1;
              if (ret_q != 0) per_d = now_q - ret_q;
              ret_d = now_q;
            end
          end
        end else if (delta < -thr_s) begin
          if (rise_q && !fall_q) begin
            rise_d = 1'b0;
            if (pen_q) begin
              if (pcond_q == wpam_pkg::COND_FALL) begin
                pause_d = 1'b1; cond_d = 1'b0;
              end else if (pcond_q == wpam_pkg::COND_LOW) begin
                pause_d = 1'b1; cond_d = 1'b1;
              end else if (pcond_q == wpam_pkg::COND_HIGH) begin
                cond_d = 1'b0;
              end
            end
          end else if (pen_q && pcond_q == wpam_pkg::COND_FALL) begin
            cond_d = 1'b0;
          end
          fall_d = 1'b1;
          last_d = dat;
        end
        state_d = S_OUT;
      end
      S_MUL: begin
        // product settles; launch divide if an average is due
        if (per_q > wpam_pkg::NO_WAVE && mcnt_q > 32'd1) begin
          div_req.start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_TICK;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          avg_d = div_rsp.quotient;
          avv_d = 1'b1;
          tot_d = '0;
          mcnt_d = '0;
          state_d = S_TICK;
        end
      end
      S_TICK: begin
        if (per_q > wpam_pkg::NO_WAVE) begin
          if ((now_q - lmt_q) > limit) begin
            lost_d = 1'b1;
            per_d = '0; ret_d = '0; ccnt_d = '0; tot_d = '0;
            mcnt_d = '0; lmt_d = '0; amp_d = '0;
          end
        end else begin
          max_d = wpam_pkg::MAX_RST;
          min_d = wpam_pkg::MIN_RST;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // threshold write clears edge counters
    if (cfg_we && cfg_index == wpam_pkg::REG_THR) begin
      ret_d = '0; ccnt_d = '0; tot_d = '0; mcnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      thr_q <= 30'd100000; pen_q <= 1'b0; pcond_q <= wpam_pkg::COND_RISE;
      spf_q <= 32'd1000; step_q <= 32'd1000;
      rise_q <= 1'b0; fall_q <= 1'b0; cond_q <= 1'b0;
      last_q <= '0; max_q <= wpam_pkg::MAX_RST; min_q <= wpam_pkg::MIN_RST;
      amp_q <= '0; dmax_q <= wpam_pkg::DISP_RST; dmin_q <= -wpam_pkg::DISP_RST;
      per_q <= '0; ret_q <= '0; lmt_q <= '0; tot_q <= '0;
      mcnt_q <= '0; ccnt_q <= '0;
    end else begin
      state_q <= state_d;
      rise_q <= rise_d; fall_q <= fall_d; cond_q <= cond_d;
      last_q <= last_d; max_q <= max_d; min_q <= min_d;
      amp_q <= amp_d; dmax_q <= dmax_d; dmin_q <= dmin_d;
      per_q <= per_d; ret_q <= ret_d; lmt_q <= lmt_d; tot_q <= tot_d;
      mcnt_q <= mcnt_d; ccnt_q <= ccnt_d;
      if (cfg_we) begin
        case (cfg_index)
          wpam_pkg::REG_THR:   thr_q   <= cfg_wdata[29:0];
          wpam_pkg::REG_PEN:   pen_q   <= cfg_wdata[0];
          wpam_pkg::REG_PCOND: pcond_q <= cfg_wdata[1:0];
          wpam_pkg::REG_SPF:   spf_q   <= cfg_wdata;
          wpam_pkg::REG_STEP:  step_q  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      now_q  <= time_ps_i;
      data_q <= 32'(voltage_a_i) + 32'(voltage_b_i);
    end
    pause_q <= pause_d; avv_q <= avv_d; lost_q <= lost_d; avg_q <= avg_d;
  end

  assign out_valid           = (state_q == S_OUT);
  assign pause_request_o     = pause_q;
  assign condition_flag_o    = cond_q;
  assign amplitude_o         = amp_q[31:0];
  assign period_ps_o         = per_q;
  assign display_max_o       = dmax_q[31:0];
  assign display_min_o       = dmin_q[31:0];
  assign average_period_ps_o = avg_q;
  assign average_valid_o     = avv_q;
  assign wave_lost_o         = lost_q;

  // sample results never carry tick flags; tick results never pause
  `WPAM_ASSERT_IMPL(a_samp_flags, clk_i, rst_ni, out_valid && !kind_q,
                    !avv_q && !lost_q)
  `WPAM_ASSERT_IMPL(a_tick_pause, clk_i, rst_ni, out_valid && kind_q, !pause_q)
  `WPAM_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, in_acc, in_stall)
endmodule

// ===== test/waveform_period_amplitude_meter_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform meter result checker
// Watches the input, output and register ports of the meter, predicts each
// result beat from its own copy of the meter state and compares field by field.
// ----------------------------------------------------------------------------
module waveform_period_amplitude_meter_core_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind_i,
  input  logic [63:0]        time_ps_i,
  input  logic signed [30:0] voltage_a_i,
  input  logic signed [30:0] voltage_b_i,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               pause_request_o,
  input  logic               condition_flag_o,
  input  logic [31:0]        amplitude_o,
  input  logic [63:0]        period_ps_o,
  input  logic signed [31:0] display_max_o,
  input  logic signed [31:0] display_min_o,
  input  logic [63:0]        average_period_ps_o,
  input  logic               average_valid_o,
  input  logic               wave_lost_o,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count_o
);

  localparam longint EXT_MAX_RESET = -64'sd4294967296;
  localparam longint EXT_MIN_RESET = 64'sd4294967295;
  localparam longint DISP_LIMIT    = 64'sd5000000;
  localparam logic [63:0] FLAT_PS  = 64'd10;

  typedef struct packed {
    logic        pause;
    logic        cond;
    logic [31:0] amp;
    logic [63:0] period;
    logic [31:0] dmax;
    logic [31:0] dmin;
    logic [63:0] avg;
    logic        avg_valid;
    logic        lost;
  } reading_t;

  reading_t readings_q[$];

  // register copies
  logic [29:0] thr_r;
  logic        pen_r;
  logic [1:0]  pcond_r;
  logic [31:0] spf_r;
  logic [31:0] step_r;

  // meter state copy
  logic        rise_seen, fall_seen, cond;
  longint      last_v, ext_max, ext_min, amp, dmax, dmin;
  logic [63:0] period, rise_t, lmax_t, total;
  logic [31:0] peak_cnt;
  logic [15:0] wave_cnt;

  task automatic clear_meter();
    thr_r = 30'd100000; pen_r = 1'b0; pcond_r = wpam_pkg::COND_RISE;
    spf_r = 32'd1000; step_r = 32'd1000;
    rise_seen = 0; fall_seen = 0; cond = 0;
    last_v = 0; ext_max = EXT_MAX_RESET; ext_min = EXT_MIN_RESET; amp = 0;
    dmax = DISP_LIMIT; dmin = -DISP_LIMIT;
    period = '0; rise_t = '0; lmax_t = '0; total = '0;
    peak_cnt = '0; wave_cnt = '0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      wpam_pkg::REG_THR: begin
        thr_r = val[29:0];
        rise_t = '0; wave_cnt = '0; total = '0; peak_cnt = '0;
      end
      wpam_pkg::REG_PEN:   pen_r = val[0];
      wpam_pkg::REG_PCOND: pcond_r = val[1:0];
      wpam_pkg::REG_SPF:   spf_r = val;
      wpam_pkg::REG_STEP:  step_r = val;
      default: ;
    endcase
  endtask

  // one beat in, one reading out
  function automatic reading_t measure_beat(input logic kind, input logic [63:0] now,
                                            input logic signed [30:0] va,
                                            input logic signed [30:0] vb);
    reading_t    r;
    longint      data, delta, thr;
    logic [63:0] limit, spf64;
    r = '0;
    if (!kind) begin
      data = longint'(va) + longint'(vb);
      thr  = longint'({34'd0, thr_r});
      if (data > ext_max) ext_max = data;
      if (data < ext_min) ext_min = data;
      delta = data - last_v;
      if (delta > 0) begin
        if (delta > thr) begin
          // rise after a fall marks a new peak
          if (fall_seen && !rise_seen) begin
            if (peak_cnt != 0) total = total + (now - lmax_t);
            lmax_t = now;
            peak_cnt = peak_cnt + 1;
            wave_cnt = wave_cnt + 1;
            fall_seen = 0;
            if (pen_r) begin
              if (pcond_r == wpam_pkg::COND_RISE || pcond_r == wpam_pkg::COND_HIGH) begin
                cond = 1; r.pause = 1;
                if (pcond_r == wpam_pkg::COND_RISE) cond = 0;
              end else if (pcond_r == wpam_pkg::COND_LOW) begin
                cond = 0;
              end
            end
          end else if (pen_r && pcond_r == wpam_pkg::COND_RISE) begin
            cond = 0;
          end
          rise_seen = 1;
          last_v = data;
        end
        // mid-level crossing after a full wave
        if (wave_cnt > 1) begin
          amp = ext_max - ext_min;
          if (2 * data >= ext_min + ext_max) begin
            if (peak_cnt > 1) begin
              dmax = ext_max; dmin = ext_min;
              ext_max = EXT_MAX_RESET; ext_min = EXT_MIN_RESET;
            end
            wave_cnt = wave_cnt - 1;
            if (rise_t != 0) period = now - rise_t;
            rise_t = now;
          end
        end
      end else if (delta < -thr) begin
        if (rise_seen && !fall_seen) begin
          rise_seen = 0;
          if (pen_r) begin
            if (pcond_r == wpam_pkg::COND_FALL || pcond_r == wpam_pkg::COND_LOW) begin
              cond = 1; r.pause = 1;
              if (pcond_r == wpam_pkg::COND_FALL) cond = 0;
            end else if (pcond_r == wpam_pkg::COND_HIGH) begin
              cond = 0;
            end
          end
        end else if (pen_r && pcond_r == wpam_pkg::COND_FALL) begin
          cond = 0;
        end
        fall_seen = 1;
        last_v = data;
      end
    end else begin
      // frame tick: average, flat-signal reset, lost-wave timeout
      if (period > FLAT_PS) begin
        if (peak_cnt > 1) begin
          r.avg = total / {32'd0, peak_cnt - 32'd1};
          r.avg_valid = 1;
          total = '0; peak_cnt = '0;
        end
        spf64 = {32'd0, spf_r};
        limit = period << 1;
        if (limit < (spf64 << 1)) limit = (spf64 * {32'd0, step_r}) << 1;
        if ((now - lmax_t) > limit) begin
          r.lost = 1;
          period = '0; rise_t = '0; wave_cnt = '0; total = '0;
          peak_cnt = '0; lmax_t = '0; amp = 0;
        end
      end else begin
        ext_max = EXT_MAX_RESET; ext_min = EXT_MIN_RESET;
      end
    end
    r.cond   = cond;
    r.amp    = amp[31:0];
    r.period = period;
    r.dmax   = dmax[31:0];
    r.dmin   = dmin[31:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h actual 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t e;
    if (!rst_ni) begin
      clear_meter();
      readings_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        readings_q.push_back(measure_beat(kind_i, time_ps_i, voltage_a_i, voltage_b_i));
      if (out_valid && !out_stall) begin
        if (readings_q.size() == 0) begin
          $error("result beat with no pending expectation");
          fail_count_o++;
        end else begin
          e = readings_q.pop_front();
          check_field("pause_request", e.pause, pause_request_o);
          check_field("condition_flag", e.cond, condition_flag_o);
          check_field("amplitude", e.amp, amplitude_o);
          check_field("period_ps", e.period, period_ps_o);
          // display fields compared as raw 32-bit patterns
          check_field("display_max", e.dmax, $unsigned(display_max_o));
          check_field("display_min", e.dmin, $unsigned(display_min_o));
          check_field("average_period_ps", e.avg, average_period_ps_o);
          check_field("average_valid", e.avg_valid, average_valid_o);
          check_field("wave_lost", e.lost, wave_lost_o);
        end
      end
    end
  end

endmodule

// ===== test/waveform_period_amplitude_meter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Waveform meter testbench
// Drives sample and frame-tick beats (triangle waves with random shape plus
// noise and extremes) across several register settings and handshake idling
// patterns; the checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------
module waveform_period_amplitude_meter_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;
  localparam longint UV_MAX     = 1000000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind_i = 1'b0;
  logic [63:0]        time_ps_i = '0;
  logic signed [30:0] voltage_a_i = '0;
  logic signed [30:0] voltage_b_i = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               pause_request_o, condition_flag_o;
  logic [31:0]        amplitude_o;
  logic [63:0]        period_ps_o;
  logic signed [31:0] display_max_o, display_min_o;
  logic [63:0]        average_period_ps_o;
  logic               average_valid_o, wave_lost_o;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;
  int                 fail_count;

  int          send_idle = 0;
  int          recv_stall = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  logic [63:0] now_ps = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  waveform_period_amplitude_meter_core dut (.*);
  waveform_period_amplitude_meter_core_checker checker_i (.*, .fail_count_o(fail_count));

  // receiver stalls
  always @(negedge clk_i) out_stall <= ($urandom_range(0, 99) < recv_stall);

  // beat counters and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) beats_in++;
      if (out_valid && !out_stall) beats_out++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("waveform_period_amplitude_meter_core_tb failed");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic kind, input longint va, input longint vb);
    while ($urandom_range(0, 99) < send_idle) @(negedge clk_i);
    kind_i = kind; time_ps_i = now_ps;
    voltage_a_i = va[30:0]; voltage_b_i = vb[30:0];
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
    beats_sent++;
  endtask

  task automatic send_sample(input longint v);
    longint va;
    va = v / 2 + longint'($urandom_range(0, 2000)) - 1000;
    now_ps += 64'($urandom_range(1, 2000));
    send_beat(1'b0, va, v - va);
  endtask

  task automatic send_tick();
    // occasionally jump far ahead so the wave is declared lost
    if ($urandom_range(0, 19) == 0) now_ps += 64'($urandom_range(1, 100000000));
    send_beat(1'b1, longint'($urandom_range(0, 2000000000)) - UV_MAX,
              longint'($urandom_range(0, 2000000000)) - UV_MAX);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (beats_out != beats_in) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // triangle wave, ticks sprinkled in
  task automatic wave_burst(input longint amp, input int halfn, input int ncyc);
    longint base;
    base = longint'($urandom_range(0, 1600000000)) - 800000000;
    for (int c = 0; c < ncyc; c++) begin
      for (int k = 0; k < 2 * halfn; k++) begin
        send_sample(base + amp * (k < halfn ? k : 2 * halfn - k) / halfn);
        if ($urandom_range(0, 11) == 0) send_tick();
      end
    end
  endtask

  task automatic random_part(input int n);
    int stop_at;
    int pick;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)
        wave_burst(longint'($urandom_range(1000000, 800000000)),
                   $urandom_range(2, 10), $urandom_range(1, 3));
      else if (pick == 7) begin
        // noise of up to +/-1000000000 on each input
        now_ps += 64'($urandom_range(1, 5000));
        if ($urandom_range(0, 9) == 0) now_ps = {$urandom, $urandom};
        send_beat(1'b0, longint'($urandom_range(0, 2000000000)) - UV_MAX,
                  longint'($urandom_range(0, 2000000000)) - UV_MAX);
      end else if (pick == 8) send_tick();
      else wave_burst(longint'($urandom_range(100000, 5000000)), 1, $urandom_range(1, 4));
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 79; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 79; end
      default: begin send_idle = 35; recv_stall = 35; end
    endcase
  endtask

  task automatic configure(input logic [31:0] thr, input logic pen, input logic [1:0] pc,
                           input logic [31:0] spf, input logic [31:0] stp);
    write_reg(wpam_pkg::REG_THR, thr);
    write_reg(wpam_pkg::REG_PEN, {31'd0, pen});
    write_reg(wpam_pkg::REG_PCOND, {30'd0, pc});
    write_reg(wpam_pkg::REG_SPF, spf);
    write_reg(wpam_pkg::REG_STEP, stp);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes with reset settings, then a clean wave
    set_idling(0);
    send_beat(1'b0, 0, 0);
    send_beat(1'b0, UV_MAX, UV_MAX);
    send_beat(1'b0, -UV_MAX, -UV_MAX);
    send_beat(1'b0, UV_MAX, -UV_MAX);
    send_beat(1'b1, 0, 0);
    now_ps = '1;
    send_beat(1'b1, -UV_MAX, UV_MAX);
    now_ps = 64'hFFFF_FFFF_FFFF_F000;   // wraps inside the burst
    wave_burst(2000000, 3, 3);
    send_tick();
    drain();

    configure(32'd100000, 1'b1, wpam_pkg::COND_RISE, 32'd1000, 32'd1000);
    write_reg(3'd5, 32'hFFFF_FFFF);     // unmapped index, ignored
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      random_part(25);
      if (ph == 2) begin
        // sender holds off until every result is back
        while (beats_out != beats_in) @(negedge clk_i);
      end
      random_part(25);
      drain();
      case (ph)
        0: configure(32'd0, 1'b1, wpam_pkg::COND_FALL, 32'd1, 32'd1);
        1: configure(32'd1, 1'b1, wpam_pkg::COND_HIGH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: configure(32'd1000000000, 1'b1, wpam_pkg::COND_LOW, 32'd1000, 32'd1);
        3: configure(32'd50000, 1'b0, wpam_pkg::COND_RISE, 32'd1, 32'hFFFF_FFFF);
        4: configure($urandom_range(0, 1000000), 1'b1, 2'($urandom_range(0, 3)),
                     $urandom, $urandom_range(1, 100));
        5: configure(32'd200000, 1'b1, wpam_pkg::COND_HIGH, 32'd10, 32'd10);
        default: configure(32'd100000, 1'b1, wpam_pkg::COND_RISE, 32'd1000, 32'd1000);
      endcase
    end

    drain();
    if (fail_count == 0) $display("waveform_period_amplitude_meter_core_tb passed");
    else $display("waveform_period_amplitude_meter_core_tb failed");
    $finish;
  end

endmodule
